### design/sn2cb_pkg.sv
package sn2cb_pkg;

  localparam int DIGITS_PER_SIDE_DEF = 4;

  localparam logic [7:0] CODE_MINUS = 8'h0A;
  localparam logic [7:0] CODE_BLANK = 8'h0F;
  localparam logic [7:0] POINT_BIT  = 8'h80;
  localparam logic [15:0] RADIX     = 16'd10;

  // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit unsigned x
  localparam logic [15:0] RECIP_DIV10 = 16'hCCCD;
  localparam int          DIV10_SHIFT = 19;

  typedef struct packed {
    logic               side;
    logic signed [15:0] number;
    logic [7:0]         point_position;
  } item_t;

  typedef struct packed {
    logic [3:0] reg_address;
    logic [7:0] reg_data;
    logic       last;
  } result_t;

  // classified item held between front and back
  typedef struct packed {
    logic        side;
    logic        neg;
    logic [15:0] mag;
    logic [7:0]  point;
  } entry_t;

endpackage

### design/sn2cb_front.sv
module sn2cb_front import sn2cb_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  output logic   item_ready,
  input  item_t  item,
  output logic   entry_valid,
  input  logic   entry_pop,
  output entry_t entry
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;
  entry_t             classified;

  assign item_ready  = (count != CNT_W'(DEPTH));
  assign entry_valid = (count != '0);
  assign push        = item_valid && item_ready;
  assign pop         = entry_pop && entry_valid;
  assign entry       = slots[rd_ptr];

  // magnitude of a two's complement value; -32768 maps to 0x8000
  always_comb begin
    classified.side  = item.side;
    classified.neg   = item.number[15];
    classified.mag   = item.number[15] ? (~item.number + 16'd1) : item.number;
    classified.point = item.point_position;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### design/sn2cb_back.sv
module sn2cb_back import sn2cb_pkg::*; #(
  parameter int DIGITS_PER_SIDE = DIGITS_PER_SIDE_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    entry_valid,
  output logic    entry_pop,
  input  entry_t  entry,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int PW = $clog2(DIGITS_PER_SIDE);
  localparam logic [PW-1:0] LAST_POS = PW'(DIGITS_PER_SIDE - 1);

  logic          busy, busy_next;
  logic [PW-1:0] pos, pos_next;
  logic [15:0]   mag, mag_next;
  logic          sign_pending, sign_pending_next;
  logic          done, done_next;
  logic          side, side_next;
  logic [7:0]    point, point_next;
  logic          res_valid, res_valid_next;
  result_t       res, res_next;

  logic          step;
  logic          load;
  logic [31:0]   prod;
  logic [15:0]   quot;
  logic [15:0]   rem;
  logic [7:0]    data;
  logic [7:0]    addr_sum;

  assign result_valid = res_valid;
  assign result       = res;
  assign entry_pop    = load;

  assign step = busy && (!res_valid || result_ready);
  assign load = entry_valid && (!busy || (step && pos == LAST_POS));

  // divide by ten through the reciprocal, remainder by shift-add
  assign prod     = 32'(mag) * 32'(RECIP_DIV10);
  assign quot     = 16'(prod >> DIV10_SHIFT);
  assign rem      = mag - ((quot << 3) + (quot << 1));
  assign addr_sum = (side ? 8'(DIGITS_PER_SIDE) : 8'd0) + 8'(pos) + 8'd1;

  always_comb begin
    busy_next         = busy;
    pos_next          = pos;
    mag_next          = mag;
    sign_pending_next = sign_pending;
    done_next         = done;
    side_next         = side;
    point_next        = point;
    res_next          = res;
    res_valid_next    = res_valid;
    data              = {4'd0, rem[3:0]};

    if (done) begin
      data = sign_pending ? CODE_MINUS : CODE_BLANK;
    end
    if (point == 8'(pos)) begin
      data = data | POINT_BIT;
    end

    if (step) begin
      res_valid_next       = 1'b1;
      res_next.reg_address = addr_sum[3:0];
      res_next.reg_data    = data;
      res_next.last        = (pos == LAST_POS);
      mag_next             = quot;
      pos_next             = pos + PW'(1);
      if (done) begin
        sign_pending_next = 1'b0;
      end else if (mag < RADIX && pos != '0) begin
        done_next = 1'b1;
      end
      if (pos == LAST_POS) begin
        busy_next = 1'b0;
      end
    end else if (result_ready) begin
      res_valid_next = 1'b0;
    end

    if (load) begin
      busy_next         = 1'b1;
      pos_next          = '0;
      mag_next          = entry.mag;
      sign_pending_next = entry.neg;
      done_next         = 1'b0;
      side_next         = entry.side;
      point_next        = entry.point;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pos          <= pos_next;
    mag          <= mag_next;
    sign_pending <= sign_pending_next;
    done         <= done_next;
    side         <= side_next;
    point        <= point_next;
    res          <= res_next;
  end

endmodule

### design/signed_number_to_code_b_digits.sv
// channel   handshake                    payload
// item      item_valid / item_ready      item   (side, number, point_position)
// result    result_valid / result_ready  result (reg_address, reg_data, last)
//
// One item gives DIGITS_PER_SIDE results, one per cycle while result is not stalled,
// least significant first; the digit sequencer, one divide-by-ten step per cycle,
// takes the next item as it sends the last result of the current one.
// A two-entry queue holds classified items while the sequencer works.
// Reset empties the queue and the result register; stalls on result hold the
// sequencer, and item is taken while the queue has room.
module signed_number_to_code_b_digits import sn2cb_pkg::*; #(
  parameter int DIGITS_PER_SIDE = DIGITS_PER_SIDE_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic   entry_valid;
  logic   entry_pop;
  entry_t entry;

  sn2cb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .entry_valid (entry_valid),
    .entry_pop   (entry_pop),
    .entry       (entry)
  );

  sn2cb_back #(
    .DIGITS_PER_SIDE (DIGITS_PER_SIDE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .entry_valid  (entry_valid),
    .entry_pop    (entry_pop),
    .entry        (entry),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
